// ----- rtl/serl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// serl_pkg
// shared types, op codes and the microcode table of the equal-range lookup
// ----------------------------------------------------------------------------
package serl_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 11;
    localparam int OP_W      = 2;
    localparam int STEP_W    = 3;

    // request op codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    typedef logic [STEP_W-1:0] t_step;

    // datapath action of one control word
    typedef enum logic [2:0] {
        A_NOP,
        A_INIT,       // lo = 0, hi = count, read first probe
        A_PROBE,      // narrow the window with the entry just read
        A_SAVE_INIT,  // keep lower bound, restart window for upper bound
        A_REPORT      // publish result from the two bounds
    } t_action;

    // sequencing of one control word
    typedef enum logic [1:0] {
        J_NEXT,       // step + 1
        J_DONE,       // to target when the window is empty, else step + 1
        J_MORE,       // to target while the window is open, else step + 1
        J_END         // program finished
    } t_jump;

    typedef struct packed {
        t_action action;
        logic    upper;   // 1: entry <= key moves right, 0: entry < key
        t_jump   jump;
        t_step   target;
    } t_ctrl;

    typedef struct packed {
        logic more;       // window after this step is still open
    } t_status;

    localparam t_step ST_LB_INIT = 3'd0;
    localparam t_step ST_LB_LOOP = 3'd1;
    localparam t_step ST_UB_INIT = 3'd2;
    localparam t_step ST_UB_LOOP = 3'd3;
    localparam t_step ST_REPORT  = 3'd4;

    function automatic t_ctrl ucode_rom(input t_step pc);
        t_ctrl w;
        unique case (pc)
            ST_LB_INIT: w = '{A_INIT,      1'b0, J_DONE, ST_UB_INIT};
            ST_LB_LOOP: w = '{A_PROBE,     1'b0, J_MORE, ST_LB_LOOP};
            ST_UB_INIT: w = '{A_SAVE_INIT, 1'b1, J_DONE, ST_REPORT};
            ST_UB_LOOP: w = '{A_PROBE,     1'b1, J_MORE, ST_UB_LOOP};
            ST_REPORT:  w = '{A_REPORT,    1'b0, J_END,  ST_LB_INIT};
            default:    w = '{A_NOP,       1'b0, J_END,  ST_LB_INIT};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/serl_sequencer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// serl_sequencer
// step counter over the microcode table, with conditional jumps
// ----------------------------------------------------------------------------
module serl_sequencer (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_go,
    input  wire serl_pkg::t_status  i_status,
    output logic                    o_busy,
    output serl_pkg::t_ctrl         o_ctrl
);
    import serl_pkg::*;

    logic  r_run, n_run;
    t_step r_pc,  n_pc;
    t_ctrl w;

    assign w = ucode_rom(r_pc);

    always_comb begin
        o_ctrl = w;
        if (!r_run) begin
            o_ctrl.action = A_NOP;
        end
    end

    assign o_busy = r_run;

    always_comb begin
        n_run = r_run;
        n_pc  = r_pc;
        if (!r_run) begin
            if (i_go) begin
                n_run = 1'b1;
                n_pc  = ST_LB_INIT;
            end
        end else begin
            unique case (w.jump)
                J_NEXT: n_pc = r_pc + 1'b1;
                J_DONE: n_pc = i_status.more ? r_pc + 1'b1 : w.target;
                J_MORE: n_pc = i_status.more ? w.target : r_pc + 1'b1;
                J_END: begin
                    n_run = 1'b0;
                    n_pc  = ST_LB_INIT;
                end
                default: n_pc = r_pc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_pc  <= ST_LB_INIT;
        end else begin
            r_run <= n_run;
            r_pc  <= n_pc;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/sorted_equal_range_lookup.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_equal_range_lookup
// sorted table of signed values with lower/upper-bound equal-range queries
// ----------------------------------------------------------------------------
// usage
//   a request is taken at a rising edge with start high and busy low
//   i_op: clear empties the table, append adds i_value at the end,
//   query looks i_value up; an unused op code is taken and ignored
//   clear and append finish in the cycle they are taken, busy stays low
//   an append to a full table, or below the last entry, is dropped
//   a query raises busy and runs a short microprogram: open the
//   lower-bound window, probe (one memory read each), open the
//   upper-bound window, probe again, then report; busy stays high
//   through the query, so a query holds the block; the table memory
//   has a single registered read port
//   the result shows on o_found/o_first_pos/o_last_pos for one cycle
//   with o_valid high, in the first cycle with busy low; positions are
//   1-based, zero when the value is absent; the receiver cannot stall
//   reset empties the table and aborts any query; no clearing pass
// ----------------------------------------------------------------------------
module sorted_equal_range_lookup #(
    parameter int DEPTH = serl_pkg::DEPTH_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                start,
    input  wire  [serl_pkg::OP_W-1:0]          i_op,
    input  wire  signed [serl_pkg::VALUE_W-1:0] i_value,
    output logic                               busy,
    output logic                               o_valid,
    output logic                               o_found,
    output logic [serl_pkg::POS_W-1:0]         o_first_pos,
    output logic [serl_pkg::POS_W-1:0]         o_last_pos
);
    import serl_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    // table memory, one write and one registered read per cycle
    logic signed [VALUE_W-1:0] mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rdata;

    logic [CW-1:0]             r_count;
    logic signed [VALUE_W-1:0] r_last;   // copy of the last entry for order check
    logic signed [VALUE_W-1:0] r_key;

    // search window and probe point
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_lb;

    logic    take;
    logic    go;
    logic    app_ok;
    logic    go_right;
    t_ctrl   ctrl;
    t_status status;

    assign take   = start && !busy;
    assign go     = take && (i_op == OP_QUERY);
    assign app_ok = (r_count < FULL) && ((r_count == '0) || (i_value >= r_last));

    serl_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_status (status),
        .o_busy   (busy),
        .o_ctrl   (ctrl)
    );

    // compare the entry read last cycle against the key
    assign go_right = ctrl.upper ? (r_rdata <= r_key) : (r_rdata < r_key);

    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        unique case (ctrl.action)
            A_INIT, A_SAVE_INIT: begin
                n_lo = '0;
                n_hi = r_count;
            end
            A_PROBE: begin
                if (go_right) begin
                    n_lo = r_mid + 1'b1;
                end else begin
                    n_hi = r_mid;
                end
            end
            default: begin
                n_lo = r_lo;
                n_hi = r_hi;
            end
        endcase
        n_mid = n_lo + ((n_hi - n_lo) >> 1);
        status.more = (n_lo < n_hi);
    end

    // memory: append writes at the fill point, the probe read runs every cycle
    always_ff @(posedge i_clk) begin
        if (take && (i_op == OP_APPEND) && app_ok) begin
            mem[r_count[AW-1:0]] <= i_value;
        end
        r_rdata <= mem[n_mid[AW-1:0]];
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_key <= i_value;
        end
        if (take && (i_op == OP_APPEND) && app_ok) begin
            r_last <= i_value;
        end
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        if (ctrl.action == A_SAVE_INIT) begin
            r_lb <= r_lo;
        end
        if (ctrl.action == A_REPORT) begin
            // lower bound below upper bound means the key is present
            o_found     <= (r_lo > r_lb);
            o_first_pos <= (r_lo > r_lb) ? POS_W'({1'b0, r_lb} + 1'b1) : '0;
            o_last_pos  <= (r_lo > r_lb) ? POS_W'(r_lo) : '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= (ctrl.action == A_REPORT);
            if (take && (i_op == OP_CLEAR)) begin
                r_count <= '0;
            end else if (take && (i_op == OP_APPEND) && app_ok) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sorted table with equal-range lookups
// ----------------------------------------------------------------------------
// a queue of pending requests is filled up front: a short directed list,
// then phases that each clear the table, append a sorted run with
// duplicates and query it. Noise between appends covers out-of-order
// appends and the unused op code. One phase fills the table past capacity.
// The driver takes requests off the queue and updates a behavioral copy
// of the table on every accepted request. Each query pushes its expected
// found flag and positions. The monitor checks every result strobe
// against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_top;
    import serl_pkg::*;

    localparam int TABLE_DEPTH = DEPTH_DEF;
    localparam int ITEMS       = 1900;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;

    // op code the block takes and ignores
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] first_pos;
        logic [POS_W-1:0] last_pos;
    } range_t;

    // clock, reset and block inputs, all known from time zero
    logic                      i_clk   = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start   = 1'b0;
    logic [OP_W-1:0]           op_d    = OP_CLEAR;
    logic signed [VALUE_W-1:0] value_d = '0;

    wire                       busy;
    wire                       o_valid;
    wire                       o_found;
    wire [POS_W-1:0]           o_first_pos;
    wire [POS_W-1:0]           o_last_pos;

    sorted_equal_range_lookup #(
        .DEPTH (TABLE_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_op        (op_d),
        .i_value     (value_d),
        .busy        (busy),
        .o_valid     (o_valid),
        .o_found     (o_found),
        .o_first_pos (o_first_pos),
        .o_last_pos  (o_last_pos)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // behavioral copy of the table
    // ------------------------------------------------------------------
    logic signed [VALUE_W-1:0] table_mem [TABLE_DEPTH];
    int unsigned               table_count;

    request_t pending_q[$];
    range_t   expected_ranges[$];

    // run statistics
    int n_errors;
    int n_planned;
    int n_queries;
    int n_hits;
    int n_kept;
    int n_drop_full;
    int n_drop_order;
    int n_clears;
    int n_ignored;
    int n_full_queries;
    int n_checked;
    int cycle_cnt;

    // first index whose entry is above the key (past_equal) or not below it
    function automatic int unsigned bound_of(input logic signed [VALUE_W-1:0] key,
                                             input bit past_equal);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = table_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (past_equal ? (table_mem[mid] <= key) : (table_mem[mid] < key)) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    // update the table copy for one accepted request, queue a result for queries
    task automatic apply_request(input logic [OP_W-1:0] op,
                                 input logic signed [VALUE_W-1:0] value);
        int unsigned lb;
        int unsigned ub;
        range_t      r;
        case (op)
            OP_CLEAR: begin
                table_count = 0;
                n_clears++;
            end
            OP_APPEND: begin
                if (table_count >= TABLE_DEPTH) begin
                    n_drop_full++;
                end else if (table_count > 0 && value < table_mem[table_count - 1]) begin
                    n_drop_order++;
                end else begin
                    table_mem[table_count] = value;
                    table_count++;
                    n_kept++;
                end
            end
            OP_QUERY: begin
                lb = bound_of(value, 1'b0);
                ub = bound_of(value, 1'b1);
                if (lb < table_count && ub > lb && table_mem[lb] == value) begin
                    r.found     = 1'b1;
                    r.first_pos = POS_W'(lb + 1);
                    r.last_pos  = POS_W'(ub);
                    n_hits++;
                end else begin
                    r = '0;
                end
                if (table_count == TABLE_DEPTH) n_full_queries++;
                n_queries++;
                expected_ranges.push_back(r);
            end
            default: begin
                n_ignored++;
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0d] mismatch: %s", cycle_cnt, what);
        n_errors++;
    endtask

    // ------------------------------------------------------------------
    // driver: one request at a time, with random idle cycles
    // ------------------------------------------------------------------
    int idle_left;

    always @(posedge i_clk) begin : drive_requests
        request_t req;
        bit       taken;
        bit       quiet;
        taken = i_rst_n && start && !busy;
        // long stretch with no idling at all
        quiet = cycle_cnt >= 6000 && cycle_cnt < 16000;
        if (taken) apply_request(op_d, value_d);
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || taken) begin
            if (idle_left > 0) begin
                idle_left--;
                start <= 1'b0;
            end else if (!quiet && pending_q.size() != 0 && $urandom_range(0, 99) < 2) begin
                idle_left = $urandom_range(0, 5);
                start <= 1'b0;
            end else if (pending_q.size() != 0) begin
                req = pending_q.pop_front();
                start   <= 1'b1;
                op_d    <= req.op;
                value_d <= req.value;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: every strobe must match the oldest expected range
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        range_t want;
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_ranges.size() == 0) begin
                report_mismatch($sformatf("result with no query pending (found=%b %0d..%0d)",
                                          o_found, o_first_pos, o_last_pos));
            end else begin
                want = expected_ranges.pop_front();
                n_checked++;
                if (o_found !== want.found)
                    report_mismatch($sformatf("found %b, expected %b", o_found, want.found));
                if (o_first_pos !== want.first_pos)
                    report_mismatch($sformatf("first_pos %0d, expected %0d",
                                              o_first_pos, want.first_pos));
                if (o_last_pos !== want.last_pos)
                    report_mismatch($sformatf("last_pos %0d, expected %0d",
                                              o_last_pos, want.last_pos));
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus planning
    // ------------------------------------------------------------------
    logic signed [VALUE_W-1:0] phase_vals[$];

    task automatic plan(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] v);
        request_t req;
        req.op    = op;
        req.value = v;
        pending_q.push_back(req);
        if (op != OP_UNUSED) n_planned++;
    endtask

    // mostly values held in the table, some neighbors, extremes and noise
    task automatic plan_query();
        logic signed [VALUE_W-1:0] v;
        int                        r;
        r = $urandom_range(0, 99);
        if (phase_vals.size() != 0 && r < 50) begin
            v = phase_vals[$urandom_range(0, phase_vals.size() - 1)];
        end else if (phase_vals.size() != 0 && r < 70) begin
            v = phase_vals[$urandom_range(0, phase_vals.size() - 1)];
            v = $urandom_range(0, 1) ? v + 1 : v - 1;
        end else if (r < 85) begin
            v = $urandom;
        end else begin
            case ($urandom_range(0, 3))
                0:       v = VAL_MIN;
                1:       v = VAL_MAX;
                2:       v = 0;
                default: v = -1;
            endcase
        end
        plan(OP_QUERY, v);
    endtask

    // clear, then a sorted run with duplicates, queries and noise mixed in
    task automatic plan_phase(input int n_app, input int max_step, input int query_pct);
        logic signed [VALUE_W-1:0] last_v;
        longint                    nv;
        int                        r;
        plan(OP_CLEAR, $urandom);
        phase_vals.delete();
        last_v = VAL_MIN;
        for (int i = 0; i < n_app; i++) begin
            r = $urandom_range(0, 99);
            if (i == 0) begin
                nv = (r < 30) ? longint'(VAL_MIN) + $urandom_range(0, 20)
                              : longint'($signed(32'($urandom)));
            end else if (r < 25) begin
                nv = last_v;
            end else if (r < 85) begin
                nv = longint'(last_v) + $urandom_range(1, max_step);
            end else begin
                nv = longint'(last_v) + ($urandom >> $urandom_range(1, 8));
            end
            if (nv > longint'(VAL_MAX)) nv = VAL_MAX;
            last_v = nv[VALUE_W-1:0];
            plan(OP_APPEND, last_v);
            if (phase_vals.size() < TABLE_DEPTH) phase_vals.push_back(last_v);
            if ($urandom_range(0, 99) < query_pct) plan_query();
            if ($urandom_range(0, 99) < 8) begin
                case ($urandom_range(0, 3))
                    0, 1: begin
                        // out-of-order append, dropped by the block
                        if (last_v != VAL_MIN) begin
                            nv = longint'(last_v) - 1 - $urandom_range(0, 1000);
                            if (nv < longint'(VAL_MIN)) nv = VAL_MIN;
                            plan(OP_APPEND, nv[VALUE_W-1:0]);
                        end else begin
                            plan(OP_UNUSED, $urandom);
                        end
                    end
                    2:       plan(OP_UNUSED, $urandom);
                    default: plan($urandom_range(0, 1) ? OP_QUERY : OP_UNUSED, $urandom);
                endcase
            end
        end
        repeat ($urandom_range(3, 10)) plan_query();
    endtask

    // ------------------------------------------------------------------
    // timeout
    // ------------------------------------------------------------------
    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("[%0d] timeout with %0d requests and %0d results outstanding",
                 cycle_cnt, pending_q.size(), expected_ranges.size());
        $display("** sorted_equal_range_lookup: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int ph;

        // directed: empty table, extremes, duplicates, dropped append,
        // unused op, absent values, clear
        plan(OP_QUERY, 0);
        plan(OP_UNUSED, -7);
        plan(OP_APPEND, VAL_MIN);
        plan(OP_APPEND, VAL_MIN);
        plan(OP_APPEND, -1);
        plan(OP_APPEND, 0);
        plan(OP_APPEND, 5);
        plan(OP_APPEND, 5);
        plan(OP_APPEND, 5);
        plan(OP_APPEND, VAL_MAX);
        plan(OP_APPEND, 3);
        plan(OP_QUERY, VAL_MIN);
        plan(OP_QUERY, 5);
        plan(OP_QUERY, VAL_MAX);
        plan(OP_QUERY, -1);
        plan(OP_QUERY, 3);
        plan(OP_QUERY, VAL_MAX - 1);
        plan(OP_UNUSED, VAL_MAX);
        plan(OP_APPEND, VAL_MAX);
        plan(OP_QUERY, VAL_MAX);
        plan(OP_CLEAR, 0);
        plan(OP_QUERY, 5);
        plan(OP_APPEND, 5);
        plan(OP_QUERY, 5);

        // random phases, the fourth one runs past a full table
        ph = 0;
        while (n_planned < ITEMS) begin
            if (ph == 3) begin
                plan_phase(TABLE_DEPTH + 16, 3, 5);
            end else begin
                plan_phase($urandom_range(0, 24), (ph % 2) ? 1000 : 200000000, 40);
            end
            ph++;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all requests taken, then all results back, then a quiet tail
        while (pending_q.size() != 0 || start) @(posedge i_clk);
        while (expected_ranges.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d queries (%0d hits, %0d on a full table), %0d results checked",
                 n_queries, n_hits, n_full_queries, n_checked);
        $display("table ops: %0d appends kept, %0d dropped full, %0d dropped out of order, "
                 , n_kept, n_drop_full, n_drop_order,
                 "%0d clears, %0d unused ops", n_clears, n_ignored);
        if (n_errors == 0) begin
            $display("** sorted_equal_range_lookup: PASSED **");
        end else begin
            $display("** sorted_equal_range_lookup: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire
